// ----- src/byte_ring_buffer_fifo_top_assert.svh -----
// assertion macros shared by the checker of the byte ring buffer fifo
// needs nothing but a clock, a reset and the signals that are checked
`ifndef BYTE_RING_BUFFER_FIFO_TOP_ASSERT_SVH
`define BYTE_RING_BUFFER_FIFO_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define BRBF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("brbf assertion failed");

// next-cycle implication, off during reset
`define BRBF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brbf assertion failed");

// next-cycle implication that also watches reset itself
`define BRBF_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("brbf assertion failed");

`endif

// ----- src/brbf_pkg.sv -----
// shared constants, codes, types and helpers of the byte ring buffer fifo
// no dependencies
package brbf_pkg;

  localparam int CAPACITY     = 1023;
  localparam int MAX_TRANSFER = 64;
  localparam int SLOTS        = CAPACITY + 1;
  localparam int POS_W        = $clog2(SLOTS);
  localparam int OP_W         = 3;
  localparam int LEN_W        = 7;
  localparam int DATA_W       = 8;
  localparam int ST_W         = 2;
  localparam int COUNT_W      = 10;
  localparam int SUM_W        = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
  localparam int CQ_DEPTH     = 4;
  localparam int CQ_AW        = $clog2(CQ_DEPTH);
  localparam int CQ_CW        = $clog2(CQ_DEPTH + 1);
  localparam int OQ_DEPTH     = 4;
  localparam int OQ_AW        = $clog2(OQ_DEPTH);
  localparam int OQ_CW        = $clog2(OQ_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_PUT    = 3'd0;
  localparam logic [OP_W-1:0] OP_DATA   = 3'd1;
  localparam logic [OP_W-1:0] OP_GET    = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
  localparam logic [OP_W-1:0] OP_STATUS = 3'd5;

  localparam logic [ST_W-1:0] ST_ACCEPTED  = 2'd0;
  localparam logic [ST_W-1:0] ST_REJECTED  = 2'd1;
  localparam logic [ST_W-1:0] ST_DELIVERED = 2'd2;
  localparam logic [ST_W-1:0] ST_DROPPED   = 2'd3;

  localparam logic [1:0] K_SINGLE = 2'd0;
  localparam logic [1:0] K_WRITE  = 2'd1;
  localparam logic [1:0] K_READ   = 2'd2;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ST_W-1:0]   status;
    pos_t              addr;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    pos_t              used;
    pos_t              free;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [DATA_W-1:0]  data;
    logic               last;
    logic [COUNT_W-1:0] used;
    logic [COUNT_W-1:0] free;
  } result_t;

  function automatic pos_t pos_inc(input pos_t p);
    if (p == POS_W'(SLOTS - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic logic [COUNT_W-1:0] to_count(input pos_t p);
    logic [31:0] w;
    w = 32'(p);
    return w[COUNT_W-1:0];
  endfunction

endpackage

// ----- src/byte_ring_buffer_fifo_top.sv -----
// byte ring buffer fifo, top level: front end, command queue, back end
// uses brbf_pkg, brbf_front, brbf_cmd_fifo and brbf_back
//
// Input channel: an item (opcode, length, data_in) is taken on a clock edge
// with push high and full low. Opcodes: put request, data byte, get, peek,
// clear, status. Result channel: while empty is low the oldest result
// (status, data_out, last, used_count, free_count) is on the ports; it is
// taken on an edge with pop high.
// The front end decides every item in the cycle it is taken, so items are
// taken one per cycle until the four-entry command queue fills.
// The back end does one step per cycle on its single store port while its result
// queue has room: one result for most items, a step and result per byte of a get or peek.
// An item's first result goes via the command queue, step registers and result queue.
// When the receiver stalls, a four-entry result queue fills, then the back
// end holds, then the command queue fills and full rises; nothing is lost.
// Reset (rst, synchronous) empties both queues and zeroes the positions and
// put bookkeeping; the byte store itself is not cleared, and no byte is read
// before it was written.
module byte_ring_buffer_fifo_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [brbf_pkg::OP_W-1:0]      opcode,
  input  logic [brbf_pkg::LEN_W-1:0]     length,
  input  logic [brbf_pkg::DATA_W-1:0]    data_in,
  input  logic                           pop,
  output logic                           empty,
  output logic [brbf_pkg::ST_W-1:0]      status,
  output logic [brbf_pkg::DATA_W-1:0]    data_out,
  output logic                           last,
  output logic [brbf_pkg::COUNT_W-1:0]   used_count,
  output logic [brbf_pkg::COUNT_W-1:0]   free_count
);

  logic cq_push, cq_full, cq_valid, cq_pop;
  brbf_pkg::cmd_t cq_in, cq_head;

  brbf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .opcode  (opcode),
    .length  (length),
    .data_in (data_in),
    .cq_push (cq_push),
    .cq_cmd  (cq_in),
    .cq_full (cq_full)
  );

  brbf_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (cq_push),
    .push_cmd (cq_in),
    .full     (cq_full),
    .pop      (cq_pop),
    .valid    (cq_valid),
    .head_cmd (cq_head)
  );

  brbf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cq_valid),
    .cmd        (cq_head),
    .cmd_pop    (cq_pop),
    .pop        (pop),
    .empty      (empty),
    .status     (status),
    .data_out   (data_out),
    .last       (last),
    .used_count (used_count),
    .free_count (free_count)
  );

endmodule

// ----- src/brbf_front.sv -----
// front end: accepts items, keeps positions and put bookkeeping, classifies
// each item into a command for the back end; uses brbf_pkg
module brbf_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [brbf_pkg::OP_W-1:0]      opcode,
  input  logic [brbf_pkg::LEN_W-1:0]     length,
  input  logic [brbf_pkg::DATA_W-1:0]    data_in,
  output logic                           cq_push,
  output brbf_pkg::cmd_t                 cq_cmd,
  input  logic                           cq_full
);

  brbf_pkg::pos_t wp, wp_next, rp, rp_next;
  logic [brbf_pkg::LEN_W-1:0] expected, expected_next;
  logic dropping, dropping_next;

  brbf_pkg::pos_t held, room;
  logic [brbf_pkg::SUM_W-1:0] held_sum, len_ext, held_ext, room_ext, rp_sum;
  brbf_pkg::pos_t rp_adv;
  logic too_long, accept;

  assign full    = cq_full;
  assign accept  = push & ~cq_full;
  assign cq_push = accept;

  always_comb begin
    held_sum = brbf_pkg::SUM_W'(wp) - brbf_pkg::SUM_W'(rp);
    if (wp < rp) begin
      held_sum = held_sum + brbf_pkg::SUM_W'(brbf_pkg::SLOTS);
    end
    held     = held_sum[brbf_pkg::POS_W-1:0];
    room     = brbf_pkg::POS_W'(brbf_pkg::CAPACITY) - held;
    len_ext  = brbf_pkg::SUM_W'(length);
    held_ext = brbf_pkg::SUM_W'(held);
    room_ext = brbf_pkg::SUM_W'(room);
    too_long = length > brbf_pkg::LEN_W'(brbf_pkg::MAX_TRANSFER);
    // read position after a get, wrapped once at most
    rp_sum = brbf_pkg::SUM_W'(rp) + len_ext;
    if (rp_sum >= brbf_pkg::SUM_W'(brbf_pkg::SLOTS)) begin
      rp_sum = rp_sum - brbf_pkg::SUM_W'(brbf_pkg::SLOTS);
    end
    rp_adv = rp_sum[brbf_pkg::POS_W-1:0];
  end

  always_comb begin
    wp_next       = wp;
    rp_next       = rp;
    expected_next = expected;
    dropping_next = dropping;
    cq_cmd.kind   = brbf_pkg::K_SINGLE;
    cq_cmd.status = brbf_pkg::ST_REJECTED;
    cq_cmd.addr   = wp;
    cq_cmd.len    = length;
    cq_cmd.data   = data_in;
    cq_cmd.used   = held;
    cq_cmd.free   = room;
    case (opcode)
      brbf_pkg::OP_PUT: begin
        expected_next = length;
        if (!too_long && len_ext <= room_ext) begin
          dropping_next = 1'b0;
          cq_cmd.status = brbf_pkg::ST_ACCEPTED;
        end else begin
          dropping_next = 1'b1;
        end
      end
      brbf_pkg::OP_DATA: begin
        cq_cmd.status = brbf_pkg::ST_DROPPED;
        if (expected == '0) begin
          dropping_next = 1'b0;
        end else begin
          expected_next = expected - 1'b1;
          if (!dropping && held != brbf_pkg::POS_W'(brbf_pkg::CAPACITY)) begin
            cq_cmd.kind   = brbf_pkg::K_WRITE;
            cq_cmd.status = brbf_pkg::ST_ACCEPTED;
            wp_next       = brbf_pkg::pos_inc(wp);
            cq_cmd.used   = held + 1'b1;
            cq_cmd.free   = room - 1'b1;
          end
          if (expected == brbf_pkg::LEN_W'(1)) begin
            dropping_next = 1'b0;
          end
        end
      end
      brbf_pkg::OP_GET, brbf_pkg::OP_PEEK: begin
        if (too_long || len_ext > held_ext) begin
          cq_cmd.status = brbf_pkg::ST_REJECTED;
        end else if (length == '0) begin
          cq_cmd.status = brbf_pkg::ST_ACCEPTED;
        end else begin
          cq_cmd.kind   = brbf_pkg::K_READ;
          cq_cmd.status = brbf_pkg::ST_DELIVERED;
          cq_cmd.addr   = rp;
          if (opcode == brbf_pkg::OP_GET) begin
            rp_next     = rp_adv;
            cq_cmd.used = held - brbf_pkg::POS_W'(length);
            cq_cmd.free = room + brbf_pkg::POS_W'(length);
          end
        end
      end
      brbf_pkg::OP_CLEAR: begin
        wp_next       = '0;
        rp_next       = '0;
        expected_next = '0;
        dropping_next = 1'b0;
        cq_cmd.status = brbf_pkg::ST_ACCEPTED;
        cq_cmd.used   = '0;
        cq_cmd.free   = brbf_pkg::POS_W'(brbf_pkg::CAPACITY);
      end
      brbf_pkg::OP_STATUS: begin
        cq_cmd.status = brbf_pkg::ST_ACCEPTED;
      end
      default: begin
        cq_cmd.status = brbf_pkg::ST_REJECTED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      rp       <= '0;
      expected <= '0;
      dropping <= 1'b0;
    end else if (accept) begin
      wp       <= wp_next;
      rp       <= rp_next;
      expected <= expected_next;
      dropping <= dropping_next;
    end
  end

endmodule

// ----- src/brbf_cmd_fifo.sv -----
// short command queue between front and back end
// uses brbf_pkg for the command type and depth
module brbf_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  brbf_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output brbf_pkg::cmd_t head_cmd
);

  brbf_pkg::cmd_t entries [brbf_pkg::CQ_DEPTH];
  logic [brbf_pkg::CQ_AW-1:0] head, tail;
  logic [brbf_pkg::CQ_CW-1:0] count;
  logic do_push, do_pop;

  assign full     = count == brbf_pkg::CQ_CW'(brbf_pkg::CQ_DEPTH);
  assign valid    = count != '0;
  assign do_push  = push & ~full;
  assign do_pop   = pop & valid;
  assign head_cmd = entries[head];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[tail] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == brbf_pkg::CQ_AW'(brbf_pkg::CQ_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (head == brbf_pkg::CQ_AW'(brbf_pkg::CQ_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      count <= count + brbf_pkg::CQ_CW'(do_push) - brbf_pkg::CQ_CW'(do_pop);
    end
  end

endmodule

// ----- src/brbf_back.sv -----
// back end: byte store, one step per cycle (store a byte, read a byte or
// report) while results fit, then a small output queue; uses brbf_pkg
module brbf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  brbf_pkg::cmd_t                cmd,
  output logic                          cmd_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic [brbf_pkg::ST_W-1:0]     status,
  output logic [brbf_pkg::DATA_W-1:0]   data_out,
  output logic                          last,
  output logic [brbf_pkg::COUNT_W-1:0]  used_count,
  output logic [brbf_pkg::COUNT_W-1:0]  free_count
);

  logic [brbf_pkg::DATA_W-1:0] mem [brbf_pkg::SLOTS];
  logic [brbf_pkg::DATA_W-1:0] rd_data;

  logic active;
  brbf_pkg::pos_t cur_pos, step_pos;
  logic [brbf_pkg::LEN_W-1:0] cur_rem, step_rem;
  logic step_last, issue, credit, is_read;

  logic b_valid, b_last, b_byte;
  logic [brbf_pkg::ST_W-1:0] b_status;
  brbf_pkg::pos_t b_used, b_free;

  brbf_pkg::result_t oq [brbf_pkg::OQ_DEPTH];
  brbf_pkg::result_t oq_in;
  logic [brbf_pkg::OQ_AW-1:0] oq_head, oq_tail;
  logic [brbf_pkg::OQ_CW-1:0] oq_count;
  logic oq_pop;

  // results in flight plus queued must leave a slot for this step
  assign credit = (brbf_pkg::OQ_CW'(1) + oq_count + brbf_pkg::OQ_CW'(b_valid))
                  <= brbf_pkg::OQ_CW'(brbf_pkg::OQ_DEPTH);
  assign issue     = cmd_valid & credit;
  assign is_read   = cmd.kind == brbf_pkg::K_READ;
  assign step_pos  = active ? cur_pos : cmd.addr;
  assign step_rem  = active ? cur_rem : cmd.len;
  assign step_last = !is_read || step_rem == brbf_pkg::LEN_W'(1);
  assign cmd_pop   = issue & step_last;

  always_ff @(posedge clk) begin
    if (issue && cmd.kind == brbf_pkg::K_WRITE) begin
      mem[cmd.addr] <= cmd.data;
    end
    if (issue && is_read) begin
      rd_data <= mem[step_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      b_valid <= issue;
      if (issue && is_read) begin
        active <= !step_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cur_pos  <= brbf_pkg::pos_inc(step_pos);
      cur_rem  <= step_rem - 1'b1;
      b_status <= cmd.status;
      b_last   <= step_last;
      b_used   <= cmd.used;
      b_free   <= cmd.free;
      b_byte   <= is_read;
    end
  end

  always_comb begin
    oq_in.status = b_status;
    oq_in.data   = b_byte ? rd_data : '0;
    oq_in.last   = b_last;
    oq_in.used   = brbf_pkg::to_count(b_used);
    oq_in.free   = brbf_pkg::to_count(b_free);
  end

  assign empty  = oq_count == '0;
  assign oq_pop = pop & ~empty;

  assign status     = oq[oq_head].status;
  assign data_out   = oq[oq_head].data;
  assign last       = oq[oq_head].last;
  assign used_count = oq[oq_head].used;
  assign free_count = oq[oq_head].free;

  always_ff @(posedge clk) begin
    if (b_valid) begin
      oq[oq_tail] <= oq_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_head  <= '0;
      oq_tail  <= '0;
      oq_count <= '0;
    end else begin
      if (b_valid) begin
        oq_tail <= (oq_tail == brbf_pkg::OQ_AW'(brbf_pkg::OQ_DEPTH - 1)) ?
                   '0 : oq_tail + 1'b1;
      end
      if (oq_pop) begin
        oq_head <= (oq_head == brbf_pkg::OQ_AW'(brbf_pkg::OQ_DEPTH - 1)) ?
                   '0 : oq_head + 1'b1;
      end
      oq_count <= oq_count + brbf_pkg::OQ_CW'(b_valid) - brbf_pkg::OQ_CW'(oq_pop);
    end
  end

endmodule

// ----- src/brbf_checker.sv -----
// port-level checker for the byte ring buffer fifo, bound to the top level
// uses brbf_pkg and the macros of byte_ring_buffer_fifo_top_assert.svh
`include "byte_ring_buffer_fifo_top_assert.svh"

module brbf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           push,
  input logic                           full,
  input logic                           pop,
  input logic                           empty,
  input logic [brbf_pkg::ST_W-1:0]      status,
  input logic [brbf_pkg::DATA_W-1:0]    data_out,
  input logic                           last,
  input logic [brbf_pkg::COUNT_W-1:0]   used_count,
  input logic [brbf_pkg::COUNT_W-1:0]   free_count
);

  logic [brbf_pkg::COUNT_W-1:0] count_sum;
  assign count_sum = used_count + free_count;

  // reset empties both queues
  `BRBF_ASSERT_NXT_ALWAYS(a_reset_empty, clk, rst, empty && !full)

  // held plus free always adds up to the capacity
  `BRBF_ASSERT_IMP(a_count_sum, clk, rst, !empty,
    count_sum == brbf_pkg::COUNT_W'(brbf_pkg::CAPACITY))

  // only delivered bytes carry data
  `BRBF_ASSERT_IMP(a_data_zero, clk, rst, !empty && status != brbf_pkg::ST_DELIVERED,
    data_out == '0)

  // a waiting transaction holds still while the receiver stalls
  `BRBF_ASSERT_NXT(a_hold, clk, rst, !empty && !pop,
    !empty && $stable(status) && $stable(data_out) && $stable(last) &&
    $stable(used_count) && $stable(free_count))

endmodule

bind byte_ring_buffer_fifo_top brbf_checker u_brbf_checker (
  .clk        (clk),
  .rst        (rst),
  .push       (push),
  .full       (full),
  .pop        (pop),
  .empty      (empty),
  .status     (status),
  .data_out   (data_out),
  .last       (last),
  .used_count (used_count),
  .free_count (free_count)
);
